FILE: rtl/scfp_pkg.sv
`default_nettype none

package scfp_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned LEN_W     = 6;
	localparam int unsigned RAW_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'h55;
	localparam logic [BYTE_W-1:0] HARD_MAX_LEN = 8'd32;
	localparam logic [BYTE_W-1:0] CMD_KEY      = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_BATTERY  = 8'h02;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOWER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_UPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd2;

	localparam logic EVENT_KEY     = 1'b0;
	localparam logic EVENT_BATTERY = 1'b1;

	localparam logic [BYTE_W-1:0] KEY_LOWER_RESET = 8'd0;
	localparam logic [BYTE_W-1:0] KEY_UPPER_RESET = 8'd255;
	localparam logic [LEN_W-1:0]  MAX_LEN_RESET   = 6'd13;

	typedef enum logic [3:0] {
		PH_HUNT1 = 4'b0001,
		PH_HUNT2 = 4'b0010,
		PH_LEN   = 4'b0100,
		PH_BODY  = 4'b1000
	} phase_t;

endpackage

`default_nettype wire

FILE: rtl/sum_checked_frame_parser.sv
// Frame parser for double-sync byte frames with an 8-bit additive checksum.
// The frame state update is a single registered stage; out_valid is registered too.
// Throughput: one byte per cycle unless out_stall holds a pending event.
// Stage one holds the received byte, stage two is the event output register.
// Reset (arst_n low, asynchronous): hunting for the first sync byte, no event pending,
// key bounds 0 and 255, maximum frame length 13.
`default_nettype none

module sum_checked_frame_parser (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [scfp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [scfp_pkg::BYTE_W-1:0]           cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [scfp_pkg::BYTE_W-1:0]           rx_byte,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic                                       event_kind,
	output logic [scfp_pkg::BYTE_W-1:0]                key_code,
	output logic [scfp_pkg::RAW_W-1:0]                 battery_raw
);

	logic [scfp_pkg::BYTE_W-1:0] key_lower_q;
	logic [scfp_pkg::BYTE_W-1:0] key_upper_q;
	logic [scfp_pkg::LEN_W-1:0]  max_len_q;

	logic                        valid_s1;
	logic [scfp_pkg::BYTE_W-1:0] byte_s1;

	scfp_pkg::phase_t            phase_q, phase_d;
	logic [scfp_pkg::LEN_W-1:0]  frame_len_q, frame_len_d;
	logic [scfp_pkg::LEN_W-1:0]  byte_count_q, byte_count_d;
	logic [scfp_pkg::BYTE_W-1:0] sum_q, sum_d;
	logic [scfp_pkg::BYTE_W-1:0] cmd_q, cmd_d;
	logic [scfp_pkg::BYTE_W-1:0] data1_q, data1_d;
	logic [scfp_pkg::BYTE_W-1:0] data2_q, data2_d;

	logic                        out_valid_q;
	logic                        event_kind_q;
	logic [scfp_pkg::BYTE_W-1:0] key_code_q;
	logic [scfp_pkg::RAW_W-1:0]  battery_raw_q;

	logic                        advance;
	logic                        last_byte;
	logic                        emit;
	logic                        emit_kind;
	logic [scfp_pkg::LEN_W-1:0]  count_inc;

	// Stage one moves on whenever the output register is free or being drained.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lower_q <= scfp_pkg::KEY_LOWER_RESET;
			key_upper_q <= scfp_pkg::KEY_UPPER_RESET;
			max_len_q   <= scfp_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scfp_pkg::CFG_KEY_LOWER: key_lower_q <= cfg_data;
				scfp_pkg::CFG_KEY_UPPER: key_upper_q <= cfg_data;
				scfp_pkg::CFG_MAX_LEN:   max_len_q   <= cfg_data[scfp_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign count_inc = byte_count_q + 1'b1;
	assign last_byte = (phase_q == scfp_pkg::PH_BODY) && (count_inc == frame_len_q);

	always_comb begin
		phase_d      = phase_q;
		frame_len_d  = frame_len_q;
		byte_count_d = byte_count_q;
		sum_d        = sum_q;
		cmd_d        = cmd_q;
		data1_d      = data1_q;
		data2_d      = data2_q;
		emit         = 1'b0;
		emit_kind    = scfp_pkg::EVENT_KEY;
		unique case (phase_q)
			scfp_pkg::PH_HUNT1: begin
				// clear the kept frame on every byte seen while hunting for the first sync byte
				frame_len_d  = '0;
				byte_count_d = '0;
				sum_d        = '0;
				cmd_d        = '0;
				data1_d      = '0;
				data2_d      = '0;
				if (byte_s1 == scfp_pkg::SYNC_BYTE) begin
					sum_d   = scfp_pkg::SYNC_BYTE;
					phase_d = scfp_pkg::PH_HUNT2;
				end
			end
			scfp_pkg::PH_HUNT2: begin
				if (byte_s1 == scfp_pkg::SYNC_BYTE) begin
					sum_d   = sum_q + scfp_pkg::SYNC_BYTE;
					phase_d = scfp_pkg::PH_LEN;
				end else begin
					phase_d = scfp_pkg::PH_HUNT1;
				end
			end
			scfp_pkg::PH_LEN: begin
				if (byte_s1 == '0 || byte_s1 > scfp_pkg::HARD_MAX_LEN
						|| byte_s1 > {2'b00, max_len_q}) begin
					phase_d = scfp_pkg::PH_HUNT1;
				end else begin
					frame_len_d  = byte_s1[scfp_pkg::LEN_W-1:0];
					sum_d        = sum_q + byte_s1;
					byte_count_d = '0;
					phase_d      = scfp_pkg::PH_BODY;
				end
			end
			scfp_pkg::PH_BODY: begin
				if (byte_count_q == 6'd0) cmd_d   = byte_s1;
				if (byte_count_q == 6'd1) data1_d = byte_s1;
				if (byte_count_q == 6'd2) data2_d = byte_s1;
				byte_count_d = count_inc;
				if (!last_byte) begin
					sum_d = sum_q + byte_s1;
				end else begin
					phase_d = scfp_pkg::PH_HUNT1;
					if (byte_s1 == sum_q) begin
						if (cmd_d == scfp_pkg::CMD_KEY) begin
							emit      = (data1_d > key_lower_q) && (data1_d < key_upper_q);
							emit_kind = scfp_pkg::EVENT_KEY;
						end else if (cmd_d == scfp_pkg::CMD_BATTERY) begin
							emit      = 1'b1;
							emit_kind = scfp_pkg::EVENT_BATTERY;
						end
					end
				end
			end
			default: begin
				phase_d = scfp_pkg::PH_HUNT1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= scfp_pkg::PH_HUNT1;
			frame_len_q  <= '0;
			byte_count_q <= '0;
			sum_q        <= '0;
			cmd_q        <= '0;
			data1_q      <= '0;
			data2_q      <= '0;
		end else if (advance) begin
			phase_q      <= phase_d;
			frame_len_q  <= frame_len_d;
			byte_count_q <= byte_count_d;
			sum_q        <= sum_d;
			cmd_q        <= cmd_d;
			data1_q      <= data1_d;
			data2_q      <= data2_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload while the event waits for its transfer
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			event_kind_q <= emit_kind;
			if (emit_kind == scfp_pkg::EVENT_BATTERY) begin
				key_code_q    <= '0;
				battery_raw_q <= {data1_d, data2_d};
			end else begin
				key_code_q    <= data1_d;
				battery_raw_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = event_kind_q;
	assign key_code    = key_code_q;
	assign battery_raw = battery_raw_q;

`ifndef NO_ASSERTIONS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with stage one empty");

	a_emit_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |-> last_byte)
		else $error("event raised before the checksum byte");

	a_end_returns_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_byte) |=> (phase_q == scfp_pkg::PH_HUNT1))
		else $error("frame end did not return to hunting");

	a_count_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == scfp_pkg::PH_BODY) |-> (byte_count_q < frame_len_q))
		else $error("body byte count ran past the frame length");

	a_event_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("pending event dropped under stall");
`endif

endmodule

`default_nettype wire
